// ===== hw/rtl/gtlfe_pkg.sv =====
// Shared types, constants and the square-root step for the flat-earth converter.
package gtlfe_pkg;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam logic [63:0] ANG_FULL = PI_Q62 / 64'd1800000000;
  localparam int unsigned ANG_W = 33;
  localparam logic [ANG_W-1:0] ANG_Q62 = ANG_FULL[ANG_W-1:0];
  localparam logic [63:0] A_MM = 64'd6378137000;
  localparam logic [63:0] E2_Q40 = 64'd7360548640;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] ONE_Q40 = 64'd1 << 40;
  localparam logic [63:0] TWO_P60 = 64'd1 << 60;
  localparam logic [127:0] M_PROD = 128'(A_MM) * (128'(ONE_Q40) - 128'(E2_Q40));
  localparam logic [63:0] M_COEF = M_PROD[103:40];
  localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;

  localparam int unsigned RAD_W = 33;
  localparam int unsigned SQ_STEPS = 32;

  localparam logic REG_HOME_LAT = 1'b0;
  localparam logic REG_HOME_LON = 1'b1;

  typedef struct packed {
    logic             ready;
    logic [30:0]      cos;
    logic [RAD_W-1:0] n_mm;
    logic [RAD_W-1:0] m_mm;
  } home_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] pair);
    sqrt_t       nxt;
    logic [35:0] r;
    logic [35:0] t;
    r = {cur.rem[33:0], pair};
    t = {2'b00, cur.root, 2'b01};
    if (r >= t) begin
      nxt.rem  = r - t;
      nxt.root = {cur.root[30:0], 1'b1};
    end else begin
      nxt.rem  = r;
      nxt.root = {cur.root[30:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/geodetic_to_local_flat_earth.sv =====
// Throughput one fix per cycle while neither out_stall_i nor the home sequencer holds the input.
// Home terms (cosine, radii) come from a shared multiply/divide/sqrt sequencer
// that runs after reset and after each home latitude write, while input is stalled.
// Reset: asynchronous active low, home point cleared to zero, pipeline emptied.
module geodetic_to_local_flat_earth #(
  parameter int unsigned TRIG_ITERATIONS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] fix_latitude_i,
  input  logic signed [31:0] fix_longitude_i,
  input  logic signed [24:0] height_mm_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] east_mm_o,
  output logic signed [31:0] north_mm_o,
  output logic [31:0]        distance_mm_o,
  output logic               overflow_o
);
  import gtlfe_pkg::*;

  logic signed [30:0] hlat_q, hlat_c;
  logic signed [31:0] hlon_q;
  logic [29:0]        hlat_mag;
  home_t              home;
  logic               adv, start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hlat_q <= '0;
      hlon_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_HOME_LAT) begin
        hlat_q <= $signed(cfg_data_i[30:0]);
      end else begin
        hlon_q <= $signed(cfg_data_i);
      end
    end
  end

  assign start = cfg_we_i && (cfg_index_i == REG_HOME_LAT);

  always_comb begin
    if (hlat_q > LAT_LIMIT) begin
      hlat_c = LAT_LIMIT;
    end else if (hlat_q < -LAT_LIMIT) begin
      hlat_c = -LAT_LIMIT;
    end else begin
      hlat_c = hlat_q;
    end
    hlat_mag = hlat_c[30] ? 30'(-hlat_c) : hlat_c[29:0];
  end

  gtlfe_home #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_home (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .hlat_mag_i (hlat_mag),
    .home_o     (home)
  );

  logic [5:0]           v_q;
  logic [SQ_STEPS-1:0]  vs_q;

  assign adv        = !vs_q[SQ_STEPS-1] || !out_stall_i;
  assign in_stall_o = !adv || !home.ready;

  // stage 1: differences and radius sums
  logic signed [31:0] dlat_w;
  logic signed [32:0] dlon_w;
  logic signed [34:0] smx_w, snx_w;
  logic        s1_nneg_q, s1_eneg_q;
  logic [30:0] s1_nmag_q;
  logic [31:0] s1_emag_q;
  logic [33:0] s1_sm_q, s1_sn_q;

  always_comb begin
    dlat_w = 32'(fix_latitude_i) - 32'(hlat_c);
    dlon_w = 33'(fix_longitude_i) - 33'(hlon_q);
    smx_w  = $signed({2'b00, home.m_mm}) + 35'(height_mm_i);
    snx_w  = $signed({2'b00, home.n_mm}) + 35'(height_mm_i);
  end

  // stage 2: angle scaling
  logic [66:0] pn_prod, pe0_prod;
  logic        s2_nneg_q, s2_eneg_q;
  logic [30:0] s2_nmag_q;
  logic [31:0] s2_emag_q;
  logic [34:0] s2_pn_q, s2_pe0_q;

  // stage 3: cosine
  logic [65:0] pe_prod;
  logic        s3_nneg_q, s3_eneg_q;
  logic [30:0] s3_nmag_q;
  logic [31:0] s3_emag_q;
  logic [34:0] s3_pn_q, s3_pe_q;

  // stage 4: offset magnitudes
  logic [65:0] nm_prod;
  logic [66:0] em_prod;
  logic        s4_nneg_q, s4_eneg_q;
  logic [35:0] s4_nmag_q;
  logic [36:0] s4_emag_q;

  // stage 5: saturation
  logic signed [31:0] north_w, east_w;
  logic               novf_w, eovf_w;
  logic signed [31:0] s5_north_q, s5_east_q;
  logic               s5_ovf_q;
  logic [31:0]        s5_an_q, s5_ae_q;

  // stage 6: sum of squares
  logic signed [31:0] s6_north_q, s6_east_q;
  logic               s6_ovf_q;
  logic [63:0]        s6_sum_q;

  always_comb begin
    pn_prod  = 67'(s1_sm_q) * 67'(ANG_Q62);
    pe0_prod = 67'(s1_sn_q) * 67'(ANG_Q62);
    pe_prod  = 66'(s2_pe0_q) * 66'(home.cos);
    nm_prod  = 66'(s3_nmag_q) * 66'(s3_pn_q);
    em_prod  = 67'(s3_emag_q) * 67'(s3_pe_q);

    novf_w = 1'b0;
    if (s4_nneg_q) begin
      if (s4_nmag_q > 36'h080000000) begin
        north_w = 32'sh80000000;
        novf_w  = 1'b1;
      end else begin
        north_w = 32'(-s4_nmag_q);
      end
    end else if (s4_nmag_q > 36'h07FFFFFFF) begin
      north_w = 32'sh7FFFFFFF;
      novf_w  = 1'b1;
    end else begin
      north_w = s4_nmag_q[31:0];
    end

    eovf_w = 1'b0;
    if (s4_eneg_q) begin
      if (s4_emag_q > 37'h080000000) begin
        east_w = 32'sh80000000;
        eovf_w = 1'b1;
      end else begin
        east_w = 32'(-s4_emag_q);
      end
    end else if (s4_emag_q > 37'h07FFFFFFF) begin
      east_w = 32'sh7FFFFFFF;
      eovf_w = 1'b1;
    end else begin
      east_w = s4_emag_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[4:0], in_valid_i && home.ready};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_nneg_q  <= dlat_w[31];
      s1_nmag_q  <= dlat_w[31] ? 31'(-dlat_w) : dlat_w[30:0];
      s1_eneg_q  <= dlon_w[32];
      s1_emag_q  <= dlon_w[32] ? 32'(-dlon_w) : dlon_w[31:0];
      s1_sm_q    <= smx_w[34] ? '0 : smx_w[33:0];
      s1_sn_q    <= snx_w[34] ? '0 : snx_w[33:0];

      s2_nneg_q  <= s1_nneg_q;
      s2_nmag_q  <= s1_nmag_q;
      s2_eneg_q  <= s1_eneg_q;
      s2_emag_q  <= s1_emag_q;
      s2_pn_q    <= pn_prod[66:32];
      s2_pe0_q   <= pe0_prod[66:32];

      s3_nneg_q  <= s2_nneg_q;
      s3_nmag_q  <= s2_nmag_q;
      s3_eneg_q  <= s2_eneg_q;
      s3_emag_q  <= s2_emag_q;
      s3_pn_q    <= s2_pn_q;
      s3_pe_q    <= pe_prod[64:30];

      s4_nneg_q  <= s3_nneg_q;
      s4_eneg_q  <= s3_eneg_q;
      s4_nmag_q  <= nm_prod[65:30];
      s4_emag_q  <= em_prod[66:30];

      s5_north_q <= north_w;
      s5_east_q  <= east_w;
      s5_ovf_q   <= novf_w || eovf_w;
      s5_an_q    <= north_w[31] ? 32'(-north_w) : north_w;
      s5_ae_q    <= east_w[31] ? 32'(-east_w) : east_w;

      s6_north_q <= s5_north_q;
      s6_east_q  <= s5_east_q;
      s6_ovf_q   <= s5_ovf_q;
      s6_sum_q   <= (64'(s5_ae_q) * 64'(s5_ae_q)) + (64'(s5_an_q) * 64'(s5_an_q));
    end
  end

  // distance: one root bit per stage
  sqrt_t              sq_q    [SQ_STEPS];
  logic [63:0]        sop_q   [SQ_STEPS];
  logic signed [31:0] snorth_q[SQ_STEPS];
  logic signed [31:0] seast_q [SQ_STEPS];
  logic               sovf_q  [SQ_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= '0;
    end else if (adv) begin
      vs_q <= {vs_q[SQ_STEPS-2:0], v_q[5]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0]     <= sqrt_step('{rem: '0, root: '0}, s6_sum_q[63:62]);
      sop_q[0]    <= s6_sum_q << 2;
      snorth_q[0] <= s6_north_q;
      seast_q[0]  <= s6_east_q;
      sovf_q[0]   <= s6_ovf_q;
    end
  end

  for (genvar k = 1; k < SQ_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k]     <= sqrt_step(sq_q[k-1], sop_q[k-1][63:62]);
        sop_q[k]    <= sop_q[k-1] << 2;
        snorth_q[k] <= snorth_q[k-1];
        seast_q[k]  <= seast_q[k-1];
        sovf_q[k]   <= sovf_q[k-1];
      end
    end
  end

  assign out_valid_o   = vs_q[SQ_STEPS-1];
  assign east_mm_o     = seast_q[SQ_STEPS-1];
  assign north_mm_o    = snorth_q[SQ_STEPS-1];
  assign distance_mm_o = sq_q[SQ_STEPS-1].root;
  assign overflow_o    = sovf_q[SQ_STEPS-1];

endmodule

// ===== hw/rtl/gtlfe_home.sv =====
// Sequencer that derives cosine and WGS84 radii from the home latitude.
module gtlfe_home #(
  parameter int unsigned TRIG_ITERATIONS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [29:0]          hlat_mag_i,
  output gtlfe_pkg::home_t     home_o
);
  import gtlfe_pkg::*;

  localparam int unsigned IW = $clog2(TRIG_ITERATIONS);
  localparam int unsigned DW = 2 * IW + 2;

  typedef enum logic [4:0] {
    ST_ANG, ST_X2, ST_INIT, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_SC, ST_Q,
    ST_SQ, ST_R, ST_N, ST_RR, ST_R3, ST_M, ST_FIN, ST_DONE, ST_WAIT
  } state_e;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT} op_e;

  state_e state_q, ret_q, l_ret;
  op_e    op_q, l_op;
  logic   l_go;
  logic [63:0] l_a, l_b;
  logic [6:0]  cnt_q;
  logic [127:0] acc_q, mc_q;
  logic [63:0]  mp_q, dvd_q, dvs_q;
  logic [64:0]  rem_q;
  logic [31:0]  root_q;
  logic [63:0]  x_q, x2_q, ts_q, tc_q, r_q;
  logic signed [63:0] as_q, ac_q;
  logic [IW-1:0] i_q;
  logic [30:0]  c_q;
  logic [RAD_W-1:0] n_q, m_q;

  logic [IW:0]   two_i, two_i_m1;
  logic [DW-1:0] div_s, div_c;
  logic [30:0]   s_w, c_w;
  logic [63:0]   q_w, d_w, prod_w;
  logic [64:0]   div_rt;
  logic          div_ge;
  sqrt_t         sq_nxt;

  function automatic logic [30:0] clamp_unit(logic signed [63:0] v);
    logic [30:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(ONE_Q30)) begin
      r = ONE_Q30[30:0];
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  always_comb begin
    two_i    = {i_q, 1'b0};
    two_i_m1 = two_i - (IW+1)'(1);
    div_s    = DW'(two_i) * DW'({i_q, 1'b1});
    div_c    = DW'(two_i_m1) * DW'(two_i);
    s_w      = clamp_unit(as_q);
    c_w      = clamp_unit(ac_q);
    prod_w   = acc_q[93:30];
    q_w      = ONE_Q40 - prod_w;
    d_w      = (root_q == '0) ? 64'd1 : 64'(root_q);
    div_rt   = {rem_q[63:0], dvd_q[63]};
    div_ge   = div_rt >= {1'b0, dvs_q};
    sq_nxt   = sqrt_step('{rem: rem_q[35:0], root: root_q}, dvd_q[63:62]);
  end

  always_comb begin
    l_go  = 1'b1;
    l_op  = OP_MUL;
    l_a   = '0;
    l_b   = '0;
    l_ret = ST_DONE;
    case (state_q)
      ST_ANG: begin
        l_a = 64'(hlat_mag_i); l_b = 64'(ANG_Q62); l_ret = ST_X2;
      end
      ST_X2: begin
        l_a = acc_q[95:32]; l_b = acc_q[95:32]; l_ret = ST_INIT;
      end
      ST_T1: begin
        l_a = ts_q; l_b = x2_q; l_ret = ST_T2;
      end
      ST_T2: begin
        l_op = OP_DIV; l_a = prod_w; l_b = 64'(div_s); l_ret = ST_T3;
      end
      ST_T3: begin
        l_a = tc_q; l_b = x2_q; l_ret = ST_T4;
      end
      ST_T4: begin
        l_op = OP_DIV; l_a = prod_w; l_b = 64'(div_c); l_ret = ST_T5;
      end
      ST_SC: begin
        l_a = 64'(s_w); l_b = 64'(s_w); l_ret = ST_Q;
      end
      ST_Q: begin
        l_a = E2_Q40; l_b = prod_w; l_ret = ST_SQ;
      end
      ST_SQ: begin
        l_op = OP_SQRT; l_a = {q_w[43:0], 20'b0}; l_ret = ST_R;
      end
      ST_R: begin
        l_op = OP_DIV; l_a = TWO_P60; l_b = d_w; l_ret = ST_N;
      end
      ST_N: begin
        l_a = A_MM; l_b = dvd_q; l_ret = ST_RR;
      end
      ST_RR: begin
        l_a = r_q; l_b = r_q; l_ret = ST_R3;
      end
      ST_R3: begin
        l_a = prod_w; l_b = r_q; l_ret = ST_M;
      end
      ST_M: begin
        l_a = M_COEF; l_b = prod_w; l_ret = ST_FIN;
      end
      default: l_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ANG;
      ret_q   <= ST_DONE;
      op_q    <= OP_MUL;
      cnt_q   <= '0;
      i_q     <= '0;
    end else if (start_i) begin
      state_q <= ST_ANG;
    end else begin
      if (l_go) begin
        op_q    <= l_op;
        ret_q   <= l_ret;
        state_q <= ST_WAIT;
        cnt_q   <= (l_op == OP_SQRT) ? 7'd32 : 7'd64;
        acc_q   <= '0;
        mc_q    <= {64'b0, l_a};
        mp_q    <= l_b;
        rem_q   <= '0;
        dvd_q   <= l_a;
        dvs_q   <= l_b;
        root_q  <= '0;
      end
      case (state_q)
        ST_X2: x_q <= acc_q[95:32];
        ST_INIT: begin
          x2_q    <= prod_w;
          ts_q    <= x_q;
          tc_q    <= ONE_Q30;
          as_q    <= $signed(x_q);
          ac_q    <= $signed(ONE_Q30);
          i_q     <= IW'(1);
          state_q <= ST_T1;
        end
        ST_T3: ts_q <= dvd_q;
        ST_T5: begin
          tc_q <= dvd_q;
          if (i_q[0]) begin
            as_q <= as_q - $signed(ts_q);
            ac_q <= ac_q - $signed(dvd_q);
          end else begin
            as_q <= as_q + $signed(ts_q);
            ac_q <= ac_q + $signed(dvd_q);
          end
          i_q     <= i_q + IW'(1);
          state_q <= (i_q == IW'(TRIG_ITERATIONS - 1)) ? ST_SC : ST_T1;
        end
        ST_SC: c_q <= c_w;
        ST_N: r_q <= dvd_q;
        ST_RR: n_q <= acc_q[RAD_W+29:30];
        ST_FIN: begin
          m_q     <= acc_q[RAD_W+29:30];
          state_q <= ST_DONE;
        end
        ST_WAIT: begin
          case (op_q)
            OP_MUL: begin
              if (mp_q[0]) begin
                acc_q <= acc_q + mc_q;
              end
              mc_q <= mc_q << 1;
              mp_q <= mp_q >> 1;
            end
            OP_DIV: begin
              rem_q <= div_ge ? (div_rt - {1'b0, dvs_q}) : div_rt;
              dvd_q <= {dvd_q[62:0], div_ge};
            end
            OP_SQRT: begin
              rem_q  <= 65'(sq_nxt.rem);
              root_q <= sq_nxt.root;
              dvd_q  <= dvd_q << 2;
            end
            default: ;
          endcase
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            state_q <= ret_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign home_o.ready = (state_q == ST_DONE);
  assign home_o.cos   = c_q;
  assign home_o.n_mm  = n_q;
  assign home_o.m_mm  = m_q;

endmodule
